// ===== rtl/uart_rxf_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_rxf_pkg
// Shared constants, register indexes and control structs for the 8N1 UART
// with receive FIFO.
// ----------------------------------------------------------------------------
package uart_rxf_pkg;

   // receive fifo geometry (holds FIFO_DEPTH-1 bytes)
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W     = 6;

   localparam int DELAY_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RX_CENTER_DELAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RX_BIT_DELAY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RX_STOP_DELAY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TX_BIT_DELAY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_INVERT     = 3'd4;

   // configuration reset values
   localparam logic [DELAY_W-1:0] RST_RX_CENTER_DELAY = 16'd50;
   localparam logic [DELAY_W-1:0] RST_RX_BIT_DELAY    = 16'd100;
   localparam logic [DELAY_W-1:0] RST_RX_STOP_DELAY   = 16'd100;
   localparam logic [DELAY_W-1:0] RST_TX_BIT_DELAY    = 16'd100;

   typedef struct packed {
      logic [DELAY_W-1:0] rx_center_delay;
      logic [DELAY_W-1:0] rx_bit_delay;
      logic [DELAY_W-1:0] rx_stop_delay;
      logic [DELAY_W-1:0] tx_bit_delay;
      logic               line_invert;
   } cfg_type;

   // byte handed from the receiver to the fifo
   typedef struct packed {
      logic       push;
      logic [7:0] data;
   } rx_push_type;

   // host requests toward the fifo
   typedef struct packed {
      logic pop;
      logic flush;
      logic restart;
   } fifo_ctl_type;

   // fifo status after one request
   typedef struct packed {
      logic              read_valid;
      logic [7:0]        read_byte;
      logic              head_valid;
      logic [FILL_W-1:0] fill_count;
      logic              overflow;
   } fifo_stat_type;

endpackage

// ===== rtl/uart_rxf_ifs.sv =====
// ----------------------------------------------------------------------------
// uart_rxf_ifs
// Valid/ready channels for requests into and responses out of the UART.
// ----------------------------------------------------------------------------
interface uart_rxf_req_if;
   logic       valid;
   logic       ready;
   logic       rx_level;
   logic       pop_req;
   logic       flush;
   logic       restart;
   logic       send_valid;
   logic [7:0] send_byte;

   modport source (output valid, output rx_level, output pop_req, output flush,
                   output restart, output send_valid, output send_byte,
                   input ready);
   modport sink   (input valid, input rx_level, input pop_req, input flush,
                   input restart, input send_valid, input send_byte,
                   output ready);
endinterface

interface uart_rxf_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_level;
   logic       tx_busy;
   logic       read_valid;
   logic [7:0] read_byte;
   logic       head_valid;
   logic [7:0] head_byte;
   logic [5:0] fill_count;
   logic       overflow;

   modport source (output valid, output tx_level, output tx_busy, output read_valid,
                   output read_byte, output head_valid, output head_byte,
                   output fill_count, output overflow, input ready);
   modport sink   (input valid, input tx_level, input tx_busy, input read_valid,
                   input read_byte, input head_valid, input head_byte,
                   input fill_count, input overflow, output ready);
endinterface

// ===== rtl/uart_rxf_top.sv =====
// ----------------------------------------------------------------------------
// uart_8n1_with_rx_fifo
// 8N1 UART transceiver with receive ring fifo; one timer tick per accepted request.
// ----------------------------------------------------------------------------
// response: registered; valid in the cycle after its request is accepted
// throughput: one request per cycle; a new request is taken while the response
//    register is empty or being drained in the same cycle
// reset: synchronous; clears rx/tx state, fifo pointers and overflow, restores
//    the delay registers to their defaults; fifo bytes are left as they are
module uart_8n1_with_rx_fifo (
   input  logic                                     clock,
   input  logic                                     reset,
   uart_rxf_req_if.sink                             req_chan,
   uart_rxf_rsp_if.source                           rsp_chan,
   input  logic                                     csr_we,
   input  logic [uart_rxf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uart_rxf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   uart_rxf_pkg::cfg_type       cfg_ff;
   uart_rxf_pkg::rx_push_type   push;
   uart_rxf_pkg::fifo_ctl_type  fifo_ctl;
   uart_rxf_pkg::fifo_stat_type stat;

   logic                                step;
   logic                                tx_level_in, tx_busy_in;
   logic [7:0]                          head_data;

   logic                                rsp_valid_ff;
   logic                                tx_level_ff, tx_busy_ff;
   logic                                read_valid_ff, head_valid_ff, overflow_ff;
   logic [7:0]                          read_byte_ff;
   logic [uart_rxf_pkg::FILL_W-1:0]     fill_ff;

   // request handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_center_delay <= uart_rxf_pkg::RST_RX_CENTER_DELAY;
         cfg_ff.rx_bit_delay    <= uart_rxf_pkg::RST_RX_BIT_DELAY;
         cfg_ff.rx_stop_delay   <= uart_rxf_pkg::RST_RX_STOP_DELAY;
         cfg_ff.tx_bit_delay    <= uart_rxf_pkg::RST_TX_BIT_DELAY;
         cfg_ff.line_invert     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            uart_rxf_pkg::REG_RX_CENTER_DELAY: cfg_ff.rx_center_delay <= csr_wdata;
            uart_rxf_pkg::REG_RX_BIT_DELAY:    cfg_ff.rx_bit_delay    <= csr_wdata;
            uart_rxf_pkg::REG_RX_STOP_DELAY:   cfg_ff.rx_stop_delay   <= csr_wdata;
            uart_rxf_pkg::REG_TX_BIT_DELAY:    cfg_ff.tx_bit_delay    <= csr_wdata;
            uart_rxf_pkg::REG_LINE_INVERT:     cfg_ff.line_invert     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign fifo_ctl.pop     = req_chan.pop_req;
   assign fifo_ctl.flush   = req_chan.flush;
   assign fifo_ctl.restart = req_chan.restart;

   uart_rxf_rx u_rx (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .level (req_chan.rx_level),
      .cfg   (cfg_ff),
      .push  (push)
   );

   uart_rxf_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .send_valid  (req_chan.send_valid),
      .send_byte   (req_chan.send_byte),
      .cfg         (cfg_ff),
      .tx_level_in (tx_level_in),
      .tx_busy_in  (tx_busy_in)
   );

   uart_rxf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .ctl       (fifo_ctl),
      .push      (push),
      .stat      (stat),
      .head_data (head_data)
   );

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (step) begin
         tx_level_ff   <= tx_level_in;
         tx_busy_ff    <= tx_busy_in;
         read_valid_ff <= stat.read_valid;
         read_byte_ff  <= stat.read_byte;
         head_valid_ff <= stat.head_valid;
         fill_ff       <= stat.fill_count;
         overflow_ff   <= stat.overflow;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tx_level   = tx_level_ff;
   assign rsp_chan.tx_busy    = tx_busy_ff;
   assign rsp_chan.read_valid = read_valid_ff;
   assign rsp_chan.read_byte  = read_byte_ff;
   assign rsp_chan.head_valid = head_valid_ff;
   assign rsp_chan.head_byte  = head_valid_ff ? head_data : 8'd0;
   assign rsp_chan.fill_count = fill_ff;
   assign rsp_chan.overflow   = overflow_ff;

endmodule

// ===== rtl/uart_rxf_rx.sv =====
// ----------------------------------------------------------------------------
// uart_rxf_rx
// Receive state machine: start detect, centre wait, 8 data samples, stop wait.
// ----------------------------------------------------------------------------
module uart_rxf_rx (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   level,
   input  uart_rxf_pkg::cfg_type  cfg,
   output uart_rxf_pkg::rx_push_type push
);

   localparam logic [1:0] RX_IDLE   = 2'd0;
   localparam logic [1:0] RX_CENTER = 2'd1;
   localparam logic [1:0] RX_BITS   = 2'd2;
   localparam logic [1:0] RX_STOP   = 2'd3;

   logic [1:0]                        phase_ff, phase_in;
   logic [uart_rxf_pkg::DELAY_W-1:0]  timer_ff, timer_in;
   logic [2:0]                        count_ff, count_in;
   logic [7:0]                        shift_ff, shift_in;

   // next state for one tick
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      push.push = 1'b0;
      push.data = shift_ff ^ {8{cfg.line_invert}};
      if (phase_ff == RX_IDLE) begin
         if (cfg.rx_stop_delay != '0 && level == cfg.line_invert) begin
            phase_in = RX_CENTER;
            timer_in = cfg.rx_center_delay;
         end
      end else if (timer_ff > 16'd1) begin
         timer_in = timer_ff - 16'd1;
      end else begin
         unique case (phase_ff)
            RX_CENTER: begin
               phase_in = RX_BITS;
               count_in = '0;
               shift_in = '0;
               timer_in = cfg.rx_bit_delay;
            end
            RX_BITS: begin
               shift_in = shift_ff | (8'(level) << count_ff);
               if (count_ff == 3'd7) begin
                  phase_in = RX_STOP;
                  timer_in = cfg.rx_stop_delay;
               end else begin
                  count_in = count_ff + 3'd1;
                  timer_in = cfg.rx_bit_delay;
               end
            end
            default: begin
               push.push = 1'b1;
               phase_in  = RX_IDLE;
               timer_in  = '0;
               count_in  = '0;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RX_IDLE;
         timer_ff <= '0;
         count_ff <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

   // receiving disabled keeps an idle receiver idle
   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == RX_IDLE && cfg.rx_stop_delay == '0 |=> phase_ff == RX_IDLE)
      else $error("rx left idle while disabled");

   // a byte is only pushed out of the stop wait
   assert property (@(posedge clock) disable iff (reset)
      push.push |-> phase_ff == RX_STOP && timer_ff <= 16'd1)
      else $error("rx push outside stop phase");

endmodule

// ===== rtl/uart_rxf_tx.sv =====
// ----------------------------------------------------------------------------
// uart_rxf_tx
// Transmit state machine: start bit, 8 data bits LSB first, stop bit.
// ----------------------------------------------------------------------------
module uart_rxf_tx (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  send_valid,
   input  logic [7:0]            send_byte,
   input  uart_rxf_pkg::cfg_type cfg,
   output logic                  tx_level_in,
   output logic                  tx_busy_in
);

   localparam logic TX_IDLE = 1'b0;
   localparam logic TX_BUSY = 1'b1;

   logic                              phase_ff, phase_in;
   logic [uart_rxf_pkg::DELAY_W-1:0]  timer_ff, timer_in;
   logic [3:0]                        count_ff, count_in;
   logic [7:0]                        shift_ff, shift_in;
   logic [3:0]                        count_inc;
   logic [2:0]                        bit_sel;
   logic                              line;

   // next state for one tick
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      count_inc = count_ff + 4'd1;
      if (phase_ff == TX_IDLE) begin
         if (send_valid && cfg.tx_bit_delay != '0) begin
            phase_in = TX_BUSY;
            shift_in = send_byte;
            count_in = '0;
            timer_in = cfg.tx_bit_delay;
         end
      end else if (timer_ff > 16'd1) begin
         timer_in = timer_ff - 16'd1;
      end else if (count_inc >= 4'd10) begin
         phase_in = TX_IDLE;
         count_in = '0;
         timer_in = '0;
      end else begin
         count_in = count_inc;
         timer_in = cfg.tx_bit_delay;
      end
   end

   // line level after this tick
   always_comb begin
      bit_sel = 3'(count_in - 4'd1);
      if (phase_in == TX_IDLE || count_in >= 4'd9) begin
         line = 1'b1;
      end else if (count_in == 4'd0) begin
         line = 1'b0;
      end else begin
         line = shift_in[bit_sel];
      end
      tx_level_in = line ^ cfg.line_invert;
      tx_busy_in  = (phase_in == TX_BUSY);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= TX_IDLE;
         timer_ff <= '0;
         count_ff <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

   // transmit disabled keeps an idle transmitter idle
   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == TX_IDLE && cfg.tx_bit_delay == '0 |=> phase_ff == TX_IDLE)
      else $error("tx started while disabled");

endmodule

// ===== rtl/uart_rxf_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_rxf_fifo
// Receive ring fifo with pop, flush, restart, sticky overflow and a registered
// head peek read from the byte memory.
// ----------------------------------------------------------------------------
module uart_rxf_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  uart_rxf_pkg::fifo_ctl_type  ctl,
   input  uart_rxf_pkg::rx_push_type   push,
   output uart_rxf_pkg::fifo_stat_type stat,
   output logic [7:0]                  head_data
);

   localparam int PW = uart_rxf_pkg::PTR_W;

   logic [7:0]    mem [uart_rxf_pkg::FIFO_DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic          overflow_ff, overflow_in;
   logic [7:0]    head_data_ff;

   logic [PW-1:0] head_a, head_b, tail_b;
   logic          nonempty, full, wr_en;
   logic [PW:0]   fill;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(uart_rxf_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // pop, then flush/restart, then receiver push
   always_comb begin
      nonempty        = (head_ff != tail_ff);
      stat.read_valid = ctl.pop && nonempty;
      stat.read_byte  = stat.read_valid ? head_data_ff : 8'd0;
      head_a          = stat.read_valid ? next_ptr(head_ff) : head_ff;
      head_b          = (ctl.flush || ctl.restart) ? '0 : head_a;
      tail_b          = (ctl.flush || ctl.restart) ? '0 : tail_ff;
      full            = (next_ptr(tail_b) == head_b);
      wr_en           = push.push && !full;
      head_in         = head_b;
      tail_in         = wr_en ? next_ptr(tail_b) : tail_b;
      overflow_in     = (overflow_ff && !ctl.restart) || (push.push && full);
      fill            = {1'b0, tail_in} - {1'b0, head_in};
      if (tail_in < head_in) begin
         fill = fill + (PW+1)'(uart_rxf_pkg::FIFO_DEPTH);
      end
      stat.head_valid = (head_in != tail_in);
      stat.fill_count = uart_rxf_pkg::FILL_W'(fill[PW-1:0]);
      stat.overflow   = overflow_in;
   end

   assign head_data = head_data_ff;

   // pointers and sticky flag
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         overflow_ff <= 1'b0;
      end else if (step) begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         overflow_ff <= overflow_in;
      end
   end

   // byte memory write
   always_ff @(posedge clock) begin
      if (step && wr_en) begin
         mem[tail_b] <= push.data;
      end
   end

   // registered head read, new byte forwarded when it lands at the head
   always_ff @(posedge clock) begin
      if (step) begin
         if (wr_en && tail_b == head_b) begin
            head_data_ff <= push.data;
         end else begin
            head_data_ff <= mem[head_b];
         end
      end
   end

   // restart always leaves the overflow flag clear
   assert property (@(posedge clock) disable iff (reset)
      step && ctl.restart |=> !overflow_ff)
      else $error("overflow survived restart");

   // flush without a push leaves the fifo empty
   assert property (@(posedge clock) disable iff (reset)
      step && (ctl.flush || ctl.restart) && !push.push |=> head_ff == tail_ff)
      else $error("fifo not empty after flush");

endmodule
